>>> rtl/core/sffr_pkg.sv
`timescale 1ns / 1ps
package sffr_pkg;

  localparam int FRAME_LEN = 92;
  localparam int POS_W     = 7;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  // Frame positions of the two check bytes
  localparam logic [POS_W-1:0] CHK_A_POS = POS_W'(FRAME_LEN - 2);
  localparam logic [POS_W-1:0] CHK_B_POS = POS_W'(FRAME_LEN - 1);
  localparam logic [POS_W-1:0] FRAME_END = POS_W'(FRAME_LEN);

  typedef struct packed {
    logic             in_frame;
    logic [POS_W-1:0] byte_index;
    logic [7:0]       data_byte;
    logic             frame_done;
    logic             checksum_ok;
  } sffr_result_t;

endpackage

>>> rtl/core/sffr_if.sv
`timescale 1ns / 1ps
interface sffr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sffr_out_if;
  logic                           valid;
  logic                           ready;
  logic                           in_frame;
  logic [sffr_pkg::POS_W-1:0]     byte_index;
  logic [7:0]                     data_byte;
  logic                           frame_done;
  logic                           checksum_ok;

  modport source (output valid, output in_frame, output byte_index, output data_byte,
                  output frame_done, output checksum_ok, input ready);
  modport sink (input valid, input in_frame, input byte_index, input data_byte,
                input frame_done, input checksum_ok, output ready);
endinterface

>>> rtl/core/sffr_frame_tracker.sv
`timescale 1ns / 1ps
module sffr_frame_tracker (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic [7:0]             rx_byte,
  output sffr_pkg::sffr_result_t res
);
  import sffr_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       sum_a_r, sum_a_nxt;
  logic [7:0]       sum_b_r, sum_b_nxt;
  logic             chk_a_ok_r, chk_a_ok_nxt;
  logic [7:0]       sum_a_add;

  assign sum_a_add = sum_a_r + rx_byte;

  always_comb begin
    pos_nxt         = '0;
    sum_a_nxt       = sum_a_r;
    sum_b_nxt       = sum_b_r;
    chk_a_ok_nxt    = chk_a_ok_r;
    res.in_frame    = 1'b0;
    res.byte_index  = '0;
    res.data_byte   = rx_byte;
    res.frame_done  = 1'b0;
    res.checksum_ok = 1'b0;

    if (pos_r == POS_W'(0)) begin
      if (rx_byte == SYNC_FIRST) begin
        res.in_frame = 1'b1;
        pos_nxt      = POS_W'(1);
      end
    end else if (pos_r == POS_W'(1)) begin
      // Mismatch drops back to hunting without retesting this byte
      if (rx_byte == SYNC_SECOND) begin
        res.in_frame   = 1'b1;
        res.byte_index = POS_W'(1);
        pos_nxt        = POS_W'(2);
        sum_a_nxt      = '0;
        sum_b_nxt      = '0;
        chk_a_ok_nxt   = 1'b0;
      end
    end else if (pos_r < FRAME_END) begin
      res.in_frame   = 1'b1;
      res.byte_index = pos_r;
      if (pos_r < CHK_A_POS) begin
        sum_a_nxt = sum_a_add;
        sum_b_nxt = sum_b_r + sum_a_add;
        pos_nxt   = pos_r + POS_W'(1);
      end else if (pos_r == CHK_A_POS) begin
        chk_a_ok_nxt = (rx_byte == sum_a_r);
        pos_nxt      = pos_r + POS_W'(1);
      end else begin
        res.frame_done  = 1'b1;
        res.checksum_ok = chk_a_ok_r && (rx_byte == sum_b_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      sum_a_r    <= '0;
      sum_b_r    <= '0;
      chk_a_ok_r <= 1'b0;
    end else if (step) begin
      pos_r      <= pos_nxt;
      sum_a_r    <= sum_a_nxt;
      sum_b_r    <= sum_b_nxt;
      chk_a_ok_r <= chk_a_ok_nxt;
    end
  end

`ifndef SYNTHESIS
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r < FRAME_END)
    else $error("frame position beyond frame length");

  a_wrap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    step && pos_r == CHK_B_POS |=> pos_r == POS_W'(0))
    else $error("no return to hunting after last frame byte");
`endif

endmodule

>>> rtl/core/sync_frame_fletcher_receiver_core.sv
`timescale 1ns / 1ps
// Sync frame receiver with an 8-bit Fletcher check (running sums modulo 256).
// Takes one received byte per item and returns one result item per byte: the
// byte echoed, whether it belongs to a frame (sync pair 0xB5 0x62, FRAME_LEN
// bytes in all), its frame position, and on the last frame byte the checksum
// verdict. Throughput is one item per clock unless out_res stalls,
// since the position counter and the running sums A and B need only one short
// update per byte. An accepted item is held in the input register and moves into
// the result register when that frees up. in_rx.ready follows out_res.ready
// combinationally through both register stages.
module sync_frame_fletcher_receiver_core (
  input  logic       clk,
  input  logic       rst_n,
  sffr_in_if.sink    in_rx,
  sffr_out_if.source out_res
);
  import sffr_pkg::*;

  logic         s1_valid_r;
  logic [7:0]   s1_byte_r;
  logic         out_valid_r;
  sffr_result_t out_r;
  sffr_result_t step_res;
  logic         adv;
  logic         in_take;

  // Advance the input register into the result register when the latter frees up
  assign adv     = s1_valid_r && (!out_valid_r || out_res.ready);
  assign in_take = in_rx.valid && in_rx.ready;

  assign in_rx.ready = !s1_valid_r || adv;

  sffr_frame_tracker u_tracker (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (adv),
    .rx_byte (s1_byte_r),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_rx.ready) begin
      s1_valid_r <= in_rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_rx.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= step_res;
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.in_frame    = out_r.in_frame;
  assign out_res.byte_index  = out_r.byte_index;
  assign out_res.data_byte   = out_r.data_byte;
  assign out_res.frame_done  = out_r.frame_done;
  assign out_res.checksum_ok = out_r.checksum_ok;

`ifndef SYNTHESIS
  a_done_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.frame_done |-> out_r.in_frame && out_r.byte_index == CHK_B_POS)
    else $error("frame end flagged off the last frame byte");

  a_ok_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.checksum_ok |-> out_r.frame_done)
    else $error("checksum verdict without frame end");

  a_reject_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.in_frame |-> out_r.byte_index == POS_W'(0))
    else $error("rejected byte carries a frame position");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r && $stable(s1_byte_r))
    else $error("input register lost a stalled item");
`endif

endmodule
